// ===== hw/rtl/ird_pkg.sv =====
`timescale 1ns / 1ps

package ird_pkg;

  // ADC reading width
  localparam int ADC_BITS = 10;

  // Signed denominator raw*256 + offset, with room for the sign
  localparam int DEN_W = ADC_BITS + 10;

  // Numerator width (largest K below 2^22); quotient has the same width
  localparam int KW = 22;
  localparam int QW = KW;
  localparam int QCNT_W = $clog2(QW + 1);

  // Result widths
  localparam int FRONT_W = 8;
  localparam int SIDE_W = 7;
  localparam int DIFF_W = 8;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Channel codes
  localparam logic [1:0] CH_FRONT = 2'd0;
  localparam logic [1:0] CH_RIGHT = 2'd1;
  localparam logic [1:0] CH_LEFT = 2'd2;

  // Calibration in Q.8
  localparam logic [KW-1:0] FRONT_K = KW'(3983821);
  localparam logic [KW-1:0] RIGHT_K = KW'(1492255);
  localparam logic [KW-1:0] LEFT_K = KW'(1624735);
  localparam logic signed [DEN_W-1:0] FRONT_OFF = DEN_W'(6551);
  localparam logic signed [DEN_W-1:0] RIGHT_OFF = DEN_W'(-743);
  localparam logic signed [DEN_W-1:0] LEFT_OFF = DEN_W'(-577);
  localparam int FRONT_C = 7;
  localparam int RIGHT_C = 2;
  localparam int LEFT_C = 3;
  localparam int FRONT_LO = 20;
  localparam int FRONT_HI = 150;
  localparam int SIDE_LO = 10;
  localparam int SIDE_HI = 80;

  // Kept distances after reset
  localparam logic [FRONT_W-1:0] FRONT_INIT = FRONT_W'(70);
  localparam logic [SIDE_W-1:0] SIDE_INIT = SIDE_W'(30);

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [KW-1:0] chan_k(input logic [1:0] ch);
    logic [KW-1:0] k;
    unique case (ch)
      CH_FRONT: k = FRONT_K;
      CH_RIGHT: k = RIGHT_K;
      default:  k = LEFT_K;
    endcase
    return k;
  endfunction

  function automatic logic signed [DEN_W-1:0] chan_off(input logic [1:0] ch);
    logic signed [DEN_W-1:0] off;
    unique case (ch)
      CH_FRONT: off = FRONT_OFF;
      CH_RIGHT: off = RIGHT_OFF;
      default:  off = LEFT_OFF;
    endcase
    return off;
  endfunction

  // Too-far code for a channel
  function automatic logic [FRONT_W-1:0] chan_far(input logic [1:0] ch);
    logic [FRONT_W-1:0] v;
    unique case (ch)
      CH_FRONT: v = FRONT_W'(FRONT_HI + 1);
      default:  v = FRONT_W'(SIDE_HI + 1);
    endcase
    return v;
  endfunction

  // Subtract the channel constant and clamp: above range -> hi+1, below -> lo-1.
  // Compared on the quotient itself so that q < c counts as below range.
  function automatic logic [FRONT_W-1:0] chan_limit(input logic [1:0] ch,
                                                    input logic [QW-1:0] q);
    logic [QW-1:0] c;
    logic [QW-1:0] lo_q;
    logic [QW-1:0] hi_q;
    logic [QW-1:0] d;
    logic [FRONT_W-1:0] v;
    unique case (ch)
      CH_FRONT: begin
        c = QW'(FRONT_C);
        lo_q = QW'(FRONT_LO + FRONT_C);
        hi_q = QW'(FRONT_HI + FRONT_C);
      end
      CH_RIGHT: begin
        c = QW'(RIGHT_C);
        lo_q = QW'(SIDE_LO + RIGHT_C);
        hi_q = QW'(SIDE_HI + RIGHT_C);
      end
      default: begin
        c = QW'(LEFT_C);
        lo_q = QW'(SIDE_LO + LEFT_C);
        hi_q = QW'(SIDE_HI + LEFT_C);
      end
    endcase
    d = q - c;
    if (q > hi_q) begin
      v = (ch == CH_FRONT) ? FRONT_W'(FRONT_HI + 1) : FRONT_W'(SIDE_HI + 1);
    end else if (q < lo_q) begin
      v = (ch == CH_FRONT) ? FRONT_W'(FRONT_LO - 1) : FRONT_W'(SIDE_LO - 1);
    end else begin
      v = d[FRONT_W-1:0];
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/ir_distance_linearizer_top.sv =====
`timescale 1ns / 1ps

// IR distance linearizer.
// Input channel (in_valid/in_ready): one set of three ADC readings, front,
// right and left. Output channel (out_valid/out_ready): the three kept
// distances in cm and left minus right, with 19/9 meaning too near and
// 151/81 too far.
// Each reading goes through one shared restoring divider (one quotient
// bit per cycle), channels in turn: front, right, left. A side reading
// whose denominator is zero or negative skips its divide and is taken
// as too far. The sequencer takes no new set until the left channel of
// the current one is done and its result is in the output register.
// in_ready is high only while the sequencer is idle. A new set is taken
// while the previous result still waits; if the receiver stalls, the
// sequencer holds the next result until the output register is taken.
// Reset (rst, synchronous) clears the handshakes, sets averaging on and
// the kept distances to 70 / 30 / 30.
// The APB port holds averaging_enable at address 0; write it while idle.
module ir_distance_linearizer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ird_pkg::PADDR_W-1:0]    paddr,
  input  logic [ird_pkg::PDATA_W-1:0]    pwdata,
  output logic [ird_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ird_pkg::ADC_BITS-1:0]   front_raw,
  input  logic [ird_pkg::ADC_BITS-1:0]   right_raw,
  input  logic [ird_pkg::ADC_BITS-1:0]   left_raw,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ird_pkg::FRONT_W-1:0]    front_cm,
  output logic [ird_pkg::SIDE_W-1:0]     right_cm,
  output logic [ird_pkg::SIDE_W-1:0]     left_cm,
  output logic signed [ird_pkg::DIFF_W-1:0] left_minus_right
);
  import ird_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_WAIT,
    S_FINISH
  } state_t;

  state_t             state;
  logic [1:0]         chan;
  logic [ADC_BITS-1:0] raw_front;
  logic [ADC_BITS-1:0] raw_right;
  logic [ADC_BITS-1:0] raw_left;
  logic [FRONT_W-1:0] nd_front;
  logic [SIDE_W-1:0]  nd_right;
  logic [SIDE_W-1:0]  nd_left;
  logic               averaging_enable;

  logic [ADC_BITS-1:0]     raw_sel;
  logic signed [DEN_W-1:0] den;
  logic                    den_far;
  logic                    div_start;
  logic [QW-1:0]           quotient;
  div_stat_t               div_stat;
  logic [FRONT_W-1:0]      chan_val;
  logic                    chan_last;
  logic                    out_free;
  logic [FRONT_W:0]        sum_front;
  logic [SIDE_W:0]         sum_right;
  logic [SIDE_W:0]         sum_left;
  logic [FRONT_W-1:0]      front_next;
  logic [SIDE_W-1:0]       right_next;
  logic [SIDE_W-1:0]       left_next;
  logic                    cfg_wr;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0);
  assign prdata = (paddr[PADDR_W-1] == 1'b0) ? PDATA_W'(averaging_enable) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      averaging_enable <= 1'b1;
    end else if (cfg_wr) begin
      averaging_enable <= pwdata[0];
    end
  end

  // Denominator of the current channel
  always_comb begin
    unique case (chan)
      CH_FRONT: raw_sel = raw_front;
      CH_RIGHT: raw_sel = raw_right;
      default:  raw_sel = raw_left;
    endcase
    den = $signed({2'b00, raw_sel, 8'b0}) + chan_off(chan);
    den_far = den[DEN_W-1] || (den == '0);
  end

  assign div_start = (state == S_LOAD) && !den_far;
  assign chan_last = (chan == CH_LEFT);

  ird_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (chan_k(chan)),
    .divisor  (den[DEN_W-2:0]),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Clamped distance of the channel finishing this cycle
  assign chan_val = (state == S_LOAD) ? chan_far(chan) : chan_limit(chan, quotient);

  // Averaging with the kept values, or the new distances alone when averaging is off
  always_comb begin
    sum_front = {1'b0, front_cm} + {1'b0, nd_front};
    sum_right = {1'b0, right_cm} + {1'b0, nd_right};
    sum_left = {1'b0, left_cm} + {1'b0, nd_left};
    if (averaging_enable) begin
      front_next = sum_front[FRONT_W:1];
      right_next = sum_right[SIDE_W:1];
      left_next = sum_left[SIDE_W:1];
    end else begin
      front_next = nd_front;
      right_next = nd_right;
      left_next = nd_left;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Sequencer, kept distances and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan <= CH_FRONT;
      out_valid <= 1'b0;
      front_cm <= FRONT_INIT;
      right_cm <= SIDE_INIT;
      left_cm <= SIDE_INIT;
      left_minus_right <= '0;
    end else begin
      // A result taken in the finish cycle is replaced there instead
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            raw_front <= front_raw;
            raw_right <= right_raw;
            raw_left <= left_raw;
            chan <= CH_FRONT;
            state <= S_LOAD;
          end
        end
        S_LOAD, S_WAIT: begin
          if ((state == S_LOAD && den_far) || (state == S_WAIT && div_stat.done)) begin
            unique case (chan)
              CH_FRONT: nd_front <= chan_val;
              CH_RIGHT: nd_right <= chan_val[SIDE_W-1:0];
              default:  nd_left <= chan_val[SIDE_W-1:0];
            endcase
            if (chan_last) begin
              state <= S_FINISH;
            end else begin
              chan <= chan + 2'd1;
              state <= S_LOAD;
            end
          end else if (state == S_LOAD) begin
            state <= S_WAIT;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            front_cm <= front_next;
            right_cm <= right_next;
            left_cm <= left_next;
            left_minus_right <= $signed({1'b0, left_next} - {1'b0, right_next});
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ird_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module ird_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ird_pkg::KW-1:0]    dividend,
  input  logic [ird_pkg::DEN_W-2:0] divisor,
  output logic [ird_pkg::QW-1:0]    quotient,
  output ird_pkg::div_stat_t        stat
);
  import ird_pkg::*;

  logic [DEN_W-1:0]  rem;
  logic [QW-1:0]     quo;
  logic [DEN_W-2:0]  dvs;
  logic [QCNT_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [DEN_W-1:0]  trial;
  logic              ge;
  logic [DEN_W-1:0]  rem_next;

  // One shift-subtract step
  always_comb begin
    trial = {rem[DEN_W-2:0], quo[QW-1]};
    ge = (trial >= {1'b0, dvs});
    rem_next = ge ? (trial - {1'b0, dvs}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
        cnt <= QCNT_W'(QW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[QW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == QCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hw/rtl/ird_checker.sv =====
`timescale 1ns / 1ps

module ird_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [ird_pkg::FRONT_W-1:0]       front_cm,
  input logic [ird_pkg::SIDE_W-1:0]        right_cm,
  input logic [ird_pkg::SIDE_W-1:0]        left_cm,
  input logic signed [ird_pkg::DIFF_W-1:0] left_minus_right
);
  import ird_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(front_cm) &&
      $stable(right_cm) && $stable(left_cm) && $stable(left_minus_right))
    else $error("stalled result changed");

  // After a transfer in, the sequencer is busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // Difference matches the side distances
  a_diff: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> left_minus_right ==
      $signed(DIFF_W'({1'b0, left_cm}) - DIFF_W'({1'b0, right_cm})))
    else $error("left_minus_right mismatch");

  // Front distance within its codes
  a_front_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> front_cm >= FRONT_W'(FRONT_LO - 1) && front_cm <= FRONT_W'(FRONT_HI + 1))
    else $error("front_cm out of range");

  // Side distances within their codes
  a_side_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> right_cm >= SIDE_W'(SIDE_LO - 1) && right_cm <= SIDE_W'(SIDE_HI + 1) &&
      left_cm >= SIDE_W'(SIDE_LO - 1) && left_cm <= SIDE_W'(SIDE_HI + 1))
    else $error("side distance out of range");

endmodule

bind ir_distance_linearizer_top ird_checker u_ird_checker (.*);
